// ===== sv/sha1_block_compression_defines.svh =====
// Assertion macros shared by the SHA-1 block compression design.
`ifndef SHA1_BLOCK_COMPRESSION_DEFINES_SVH
`define SHA1_BLOCK_COMPRESSION_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SHABC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SHABC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/shabc_pkg.sv =====
package shabc_pkg;

   localparam int WORD_W      = 32;
   localparam int DIGEST_W    = 5;
   localparam int WINDOW      = 16;
   localparam int ROUNDS      = 80;
   localparam int PHASE_LEN   = 20;
   localparam int POS_W       = $clog2(WINDOW);
   localparam int ROUND_W     = $clog2(ROUNDS);
   localparam int INDEX_W     = 3;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type INIT_VALUE [DIGEST_W] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   typedef enum logic [1:0] {
      PHASE_CHOOSE,
      PHASE_PARITY_LOW,
      PHASE_MAJORITY,
      PHASE_PARITY_HIGH
   } phase_type;

   typedef struct packed {
      logic [WORD_W-1:0] message_word;
      logic              first_of_message;
      logic              last_of_message;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  digest_word;
      logic [INDEX_W-1:0] digest_index;
      logic               digest_done;
   } rsp_type;

   typedef struct packed {
      logic               load_word;
      logic               init_chain;
      logic               load_work;
      logic               round_en;
      phase_type          phase;
      logic               add_chain;
      logic [INDEX_W-1:0] emit_index;
   } cmd_type;

   function automatic word_type round_constant(input phase_type phase);
      word_type k;
      case (phase)
         PHASE_CHOOSE:      k = 32'h5a827999;
         PHASE_PARITY_LOW:  k = 32'h6ed9eba1;
         PHASE_MAJORITY:    k = 32'h8f1bbcdc;
         PHASE_PARITY_HIGH: k = 32'hca62c1d6;
         default:           k = 32'h5a827999;
      endcase
      return k;
   endfunction

   function automatic word_type round_function(input phase_type phase, input word_type b,
                                               input word_type c, input word_type d);
      word_type f;
      case (phase)
         PHASE_CHOOSE:   f = (b & c) | (~b & d);
         PHASE_MAJORITY: f = (b & c) | (b & d) | (c & d);
         default:        f = b ^ c ^ d;
      endcase
      return f;
   endfunction

endpackage

// ===== sv/shabc_ctrl.sv =====
module shabc_ctrl import shabc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_first,
   input  logic    req_last,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(WINDOW - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(DIGEST_W - 1);

   state_type           state_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [ROUND_W-1:0]  round_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic                last_ff;
   logic                valid_ff;
   phase_type           phase;
   logic                accept;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (round_ff < ROUND_W'(PHASE_LEN)) begin
         phase = PHASE_CHOOSE;
      end else if (round_ff < ROUND_W'(2 * PHASE_LEN)) begin
         phase = PHASE_PARITY_LOW;
      end else if (round_ff < ROUND_W'(3 * PHASE_LEN)) begin
         phase = PHASE_MAJORITY;
      end else begin
         phase = PHASE_PARITY_HIGH;
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.phase      = phase;
      cmd.emit_index = index_ff;
      cmd.load_word  = accept;
      cmd.init_chain = accept && req_first && (pos_ff == '0);
      cmd.load_work  = accept && (pos_ff == LAST_POS);
      cmd.round_en   = (state_ff == ST_ROUND);
      cmd.add_chain  = (state_ff == ST_ADD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         pos_ff   <= '0;
         round_ff <= '0;
         index_ff <= '0;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  pos_ff <= pos_ff + 1'b1;
                  if (pos_ff == LAST_POS) begin
                     last_ff  <= req_last;
                     round_ff <= '0;
                     state_ff <= ST_ROUND;
                  end
               end
            end
            ST_ROUND: begin
               if (round_ff == LAST_ROUND) begin
                  state_ff <= ST_ADD;
               end else begin
                  round_ff <= round_ff + 1'b1;
               end
            end
            ST_ADD: begin
               if (last_ff) begin
                  index_ff <= '0;
                  valid_ff <= 1'b1;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  if (index_ff == LAST_INDEX) begin
                     valid_ff <= 1'b0;
                     state_ff <= ST_LOAD;
                  end else begin
                     index_ff <= index_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

endmodule

// ===== sv/shabc_datapath.sv =====
module shabc_datapath import shabc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  word_type message_word,
   output rsp_type  rsp_payload
);

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(DIGEST_W - 1);

   word_type chain_ff  [DIGEST_W];
   word_type chain_in  [DIGEST_W];
   word_type work_ff   [DIGEST_W];
   word_type work_in   [DIGEST_W];
   word_type window_ff [WINDOW];
   word_type window_in [WINDOW];
   word_type expand_sum;
   word_type expanded;
   word_type round_sum;

   // The window is a shift line: entry zero always holds the word for the current round.
   always_comb begin
      expand_sum = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
      expanded   = {expand_sum[WORD_W-2:0], expand_sum[WORD_W-1]};
      round_sum  = {work_ff[0][WORD_W-6:0], work_ff[0][WORD_W-1:WORD_W-5]}
                 + round_function(cmd.phase, work_ff[1], work_ff[2], work_ff[3])
                 + work_ff[4] + window_ff[0] + round_constant(cmd.phase);
   end

   always_comb begin
      window_in = window_ff;
      if (cmd.load_word || cmd.round_en) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[WINDOW - 1] = cmd.load_word ? message_word : expanded;
      end
   end

   always_comb begin
      work_in = work_ff;
      if (cmd.load_work) begin
         work_in = chain_ff;
      end else if (cmd.round_en) begin
         work_in[0] = round_sum;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][WORD_W-1:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (cmd.init_chain) begin
         chain_in = INIT_VALUE;
      end else if (cmd.add_chain) begin
         for (int i = 0; i < DIGEST_W; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      work_ff   <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_VALUE;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_comb begin
      rsp_payload.digest_word  = chain_ff[cmd.emit_index];
      rsp_payload.digest_index = cmd.emit_index;
      rsp_payload.digest_done  = (cmd.emit_index == LAST_INDEX);
   end

endmodule

// ===== sv/sha1_block_compression.sv =====
// SHA-1 compression core for already padded messages. Each transaction on the
// request channel carries one big-endian 32-bit word; sixteen words make a block.
// Loading a block takes sixteen transactions at up to one per cycle. The sixteenth
// word starts the compression, which runs one round per cycle in a single round
// unit for all 80 rounds, followed by a step that adds the result into the chaining
// value; the request channel is held off during that time. When the sixteenth
// word carries the last-of-message flag, the five digest words follow on the
// response channel, one per cycle while the consumer is ready, and no request is
// taken until the fifth has been taken. The first-of-message flag counts only on
// a block's first word.
`include "sha1_block_compression_defines.svh"

module sha1_block_compression import shabc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type cmd;

   shabc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_first (req_payload.first_of_message),
      .req_last  (req_payload.last_of_message),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   shabc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .message_word (req_payload.message_word),
      .rsp_payload  (rsp_payload)
   );

   `SHABC_ASSERT_SAME(a_no_request_while_emitting, rsp_valid, !req_ready, "request taken during digest output")
   `SHABC_ASSERT_SAME(a_no_request_while_rounds, cmd.round_en, !req_ready && !rsp_valid, "request or response during rounds")
   `SHABC_ASSERT_NEXT(a_block_starts_rounds, cmd.load_work, cmd.round_en, "compression did not start after a full block")
   `SHABC_ASSERT_NEXT(a_digest_ends, rsp_valid && rsp_ready && rsp_payload.digest_done, !rsp_valid, "response after final digest word")

endmodule
